@@ hw/rtl/sbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and constants of the score sorted box suppression block.
// ----------------------------------------------------------------------------
package sbs_pkg;

    localparam int MAX_CANDIDATES_DEF = 1024;
    localparam int MAX_KEEP_DEF       = 64;

    localparam int EDGE_W  = 14;
    localparam int SCORE_W = 16;
    localparam int TAG_W   = 10;
    localparam int LIMIT_W = 7;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LIMIT  = 2'd2;

    localparam logic [SCORE_W-1:0] SCORE_THR_RST   = 16'd16384;
    localparam logic [SCORE_W-1:0] OVERLAP_THR_RST = 16'd29491;
    localparam logic [LIMIT_W-1:0] KEEP_LIMIT_RST  = 7'd64;

    localparam logic KIND_FINISH = 1'b1;

    typedef struct packed {
        logic [EDGE_W-1:0]  left;
        logic [EDGE_W-1:0]  top;
        logic [EDGE_W-1:0]  right;
        logic [EDGE_W-1:0]  bottom;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic finish;
        rec_t rec;
    } cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/sbs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbs_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/sbs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbs_front
// Input side: drops low scoring candidates and queues the rest, with finish
// words, in a two word queue towards the back end.
// ----------------------------------------------------------------------------
module sbs_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         kind,
    input  wire logic [sbs_pkg::EDGE_W-1:0]   left_edge,
    input  wire logic [sbs_pkg::EDGE_W-1:0]   top_edge,
    input  wire logic [sbs_pkg::EDGE_W-1:0]   right_edge,
    input  wire logic [sbs_pkg::EDGE_W-1:0]   bottom_edge,
    input  wire logic [sbs_pkg::SCORE_W-1:0]  confidence,
    input  wire logic [sbs_pkg::TAG_W-1:0]    tag,
    input  wire logic [sbs_pkg::SCORE_W-1:0]  score_thr,
    output logic                              cmd_valid,
    output sbs_pkg::cmd_t                     cmd,
    input  wire logic                         cmd_ready
);

    sbs_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;
    sbs_pkg::cmd_t in_cmd;

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    assign in_cmd.finish     = (kind == sbs_pkg::KIND_FINISH);
    assign in_cmd.rec.left   = left_edge;
    assign in_cmd.rec.top    = top_edge;
    assign in_cmd.rec.right  = right_edge;
    assign in_cmd.rec.bottom = bottom_edge;
    assign in_cmd.rec.score  = confidence;
    assign in_cmd.rec.tag    = tag;

    // scores below threshold never reach the store
    assign push = in_valid && in_ready
                  && (in_cmd.finish || (confidence >= score_thr));
    assign pop  = cmd_valid && cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/sbs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbs_back
// Execution side: fills the candidate store, then on finish picks boxes in
// score order by repeated scans, tests them against the kept list and emits.
// ----------------------------------------------------------------------------
module sbs_back #(
    parameter int MAX_CANDIDATES = sbs_pkg::MAX_CANDIDATES_DEF,
    parameter int MAX_KEEP       = sbs_pkg::MAX_KEEP_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    input  wire sbs_pkg::cmd_t                 cmd,
    output logic                               cmd_ready,
    input  wire logic [sbs_pkg::SCORE_W-1:0]   overlap_threshold,
    input  wire logic [sbs_pkg::LIMIT_W-1:0]   keep_limit,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               out_found,
    output sbs_pkg::rec_t                      out_rec,
    output logic                               out_overflowed,
    output logic                               out_last
);

    localparam int AW   = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CW   = $clog2(MAX_CANDIDATES + 1);
    localparam int KW   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int KCW  = $clog2(MAX_KEEP + 1);
    localparam int KEYW = sbs_pkg::SCORE_W + AW;
    localparam int EW   = sbs_pkg::EDGE_W;
    localparam int PW   = 2 * EW;
    localparam int UW   = PW + 1;
    localparam int TW   = UW + sbs_pkg::SCORE_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CANDIDATES);
    localparam logic [sbs_pkg::LIMIT_W-1:0] LIM_MAX = sbs_pkg::LIMIT_W'(MAX_KEEP);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_PICK_RD, ST_PICK_LD, ST_CMP_RD, ST_CMP_S1, ST_CMP_S2,
        ST_CMP_S3, ST_CMP_S4, ST_CMP_S5, ST_KEEP, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_WAIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                drop_reg, drop_next;
    logic [KCW-1:0]      kept_reg, kept_next;
    logic [CW-1:0]       scan_addr_reg, scan_addr_next;
    logic                scan_vld_reg, scan_vld_next;
    logic [AW-1:0]       scan_idx_reg, scan_idx_next;
    logic                found_reg, found_next;
    logic                first_reg, first_next;
    logic [KEYW-1:0]     best_key_reg, best_key_next;
    logic [KEYW-1:0]     prev_key_reg, prev_key_next;
    sbs_pkg::rec_t       cand_reg, cand_next;
    logic [KW-1:0]       j_reg, j_next;
    logic [KW-1:0]       e_reg, e_next;
    logic [EW-1:0]       iw_reg, iw_next, ih_reg, ih_next;
    logic [EW-1:0]       aw_reg, aw_next, ah_reg, ah_next;
    logic [EW-1:0]       bw_reg, bw_next, bh_reg, bh_next;
    logic [PW-1:0]       inter_reg, inter_next;
    logic [PW-1:0]       area_a_reg, area_a_next, area_b_reg, area_b_next;
    logic [UW-1:0]       uni_reg, uni_next;
    logic [TW-1:0]       prod_reg, prod_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg, out_found_next;
    logic                out_last_reg, out_last_next;
    logic                out_ovf_reg, out_ovf_next;
    sbs_pkg::rec_t       out_rec_reg, out_rec_next;

    logic                s_wr_en;
    logic [AW-1:0]       s_rd_addr;
    logic [sbs_pkg::REC_W-1:0] s_rd_bits, k_rd_bits;
    sbs_pkg::rec_t       s_rd, k_rd;
    logic                k_wr_en;
    logic [KW-1:0]       k_rd_addr;
    logic [sbs_pkg::LIMIT_W-1:0] lim_full;
    logic [KCW-1:0]      lim;
    logic                issue;
    logic [KEYW-1:0]     cur_key;
    logic [EW-1:0]       ix1, iy1, ix2, iy2;

    assign s_rd = sbs_pkg::rec_t'(s_rd_bits);
    assign k_rd = sbs_pkg::rec_t'(k_rd_bits);

    assign cmd_ready = (state_reg == ST_IDLE);
    assign s_wr_en   = (state_reg == ST_IDLE) && cmd_valid && !cmd.finish
                       && (count_reg < CNT_MAX);
    assign k_wr_en   = (state_reg == ST_KEEP);
    assign s_rd_addr = (state_reg == ST_PICK_RD) ? ~best_key_reg[AW-1:0]
                                                 : scan_addr_reg[AW-1:0];
    assign k_rd_addr = (state_reg == ST_EMIT_RD) ? e_reg : j_reg;

    assign lim_full = (keep_limit == '0) ? sbs_pkg::LIMIT_W'(1)
                    : ((keep_limit > LIM_MAX) ? LIM_MAX : keep_limit);
    assign lim      = lim_full[KCW-1:0];

    assign issue   = (scan_addr_reg < count_reg);
    // lower index wins a tie, hence the inverted index in the low bits
    assign cur_key = {s_rd.score, ~scan_idx_reg};

    assign ix1 = (cand_reg.left > k_rd.left) ? cand_reg.left : k_rd.left;
    assign iy1 = (cand_reg.top > k_rd.top) ? cand_reg.top : k_rd.top;
    assign ix2 = (cand_reg.right < k_rd.right) ? cand_reg.right : k_rd.right;
    assign iy2 = (cand_reg.bottom < k_rd.bottom) ? cand_reg.bottom : k_rd.bottom;

    sbs_ram #(.WIDTH(sbs_pkg::REC_W), .DEPTH(MAX_CANDIDATES)) u_store (
        .clk     (clk),
        .wr_en   (s_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (cmd.rec),
        .rd_addr (s_rd_addr),
        .rd_data (s_rd_bits)
    );

    sbs_ram #(.WIDTH(sbs_pkg::REC_W), .DEPTH(MAX_KEEP)) u_kept (
        .clk     (clk),
        .wr_en   (k_wr_en),
        .wr_addr (kept_reg[KW-1:0]),
        .wr_data (cand_reg),
        .rd_addr (k_rd_addr),
        .rd_data (k_rd_bits)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        kept_next      = kept_reg;
        scan_addr_next = scan_addr_reg;
        scan_vld_next  = 1'b0;
        scan_idx_next  = scan_idx_reg;
        found_next     = found_reg;
        first_next     = first_reg;
        best_key_next  = best_key_reg;
        prev_key_next  = prev_key_reg;
        cand_next      = cand_reg;
        j_next         = j_reg;
        e_next         = e_reg;
        iw_next        = iw_reg;
        ih_next        = ih_reg;
        aw_next        = aw_reg;
        ah_next        = ah_reg;
        bw_next        = bw_reg;
        bh_next        = bh_reg;
        inter_next     = inter_reg;
        area_a_next    = area_a_reg;
        area_b_next    = area_b_reg;
        uni_next       = uni_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_rec_next   = out_rec_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.finish)
                    begin
                        kept_next      = '0;
                        first_next     = 1'b1;
                        found_next     = 1'b0;
                        scan_addr_next = '0;
                        state_next     = ST_SCAN;
                    end
                    else if (count_reg < CNT_MAX)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    scan_addr_next = scan_addr_reg + CW'(1);
                    scan_vld_next  = 1'b1;
                    scan_idx_next  = scan_addr_reg[AW-1:0];
                end
                if (scan_vld_reg && (first_reg || (cur_key < prev_key_reg))
                    && (!found_reg || (cur_key > best_key_reg)))
                begin
                    best_key_next = cur_key;
                    found_next    = 1'b1;
                end
                if (!issue && !scan_vld_reg)
                begin
                    e_next     = '0;
                    state_next = found_reg ? ST_PICK_RD : ST_EMIT_RD;
                end
            end
            ST_PICK_RD:
            begin
                state_next = ST_PICK_LD;
            end
            ST_PICK_LD:
            begin
                cand_next     = s_rd;
                prev_key_next = best_key_reg;
                first_next    = 1'b0;
                j_next        = '0;
                state_next    = (kept_reg == '0) ? ST_KEEP : ST_CMP_RD;
            end
            ST_CMP_RD:
            begin
                state_next = ST_CMP_S1;
            end
            ST_CMP_S1:
            begin
                iw_next    = (ix2 > ix1) ? ix2 - ix1 : '0;
                ih_next    = (iy2 > iy1) ? iy2 - iy1 : '0;
                aw_next    = (cand_reg.right > cand_reg.left)
                             ? cand_reg.right - cand_reg.left : '0;
                ah_next    = (cand_reg.bottom > cand_reg.top)
                             ? cand_reg.bottom - cand_reg.top : '0;
                bw_next    = (k_rd.right > k_rd.left) ? k_rd.right - k_rd.left : '0;
                bh_next    = (k_rd.bottom > k_rd.top) ? k_rd.bottom - k_rd.top : '0;
                state_next = ST_CMP_S2;
            end
            ST_CMP_S2:
            begin
                inter_next  = PW'(iw_reg) * PW'(ih_reg);
                area_a_next = PW'(aw_reg) * PW'(ah_reg);
                area_b_next = PW'(bw_reg) * PW'(bh_reg);
                state_next  = ST_CMP_S3;
            end
            ST_CMP_S3:
            begin
                uni_next   = UW'(area_a_reg) + UW'(area_b_reg) - UW'(inter_reg);
                state_next = ST_CMP_S4;
            end
            ST_CMP_S4:
            begin
                prod_next  = TW'(overlap_threshold) * TW'(uni_reg);
                state_next = ST_CMP_S5;
            end
            ST_CMP_S5:
            begin
                // a zero union gives zero intersection, so never suppresses
                if (TW'({inter_reg, 16'd0}) > prod_reg)
                begin
                    found_next     = 1'b0;
                    scan_addr_next = '0;
                    state_next     = ST_SCAN;
                end
                else if (KCW'(j_reg) + KCW'(1) == kept_reg)
                begin
                    state_next = ST_KEEP;
                end
                else
                begin
                    j_next     = j_reg + KW'(1);
                    state_next = ST_CMP_RD;
                end
            end
            ST_KEEP:
            begin
                kept_next = kept_reg + KCW'(1);
                if (kept_reg + KCW'(1) == lim)
                begin
                    e_next     = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    found_next     = 1'b0;
                    scan_addr_next = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_found_next = (kept_reg != '0);
                out_ovf_next   = drop_reg;
                out_rec_next   = (kept_reg == '0) ? '0 : k_rd;
                out_last_next  = (kept_reg == '0)
                                 || (KCW'(e_reg) + KCW'(1) == kept_reg);
                state_next     = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        e_next     = e_reg + KW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            kept_reg      <= '0;
            scan_addr_reg <= '0;
            scan_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            kept_reg      <= kept_next;
            scan_addr_reg <= scan_addr_next;
            scan_vld_reg  <= scan_vld_next;
            found_reg     <= found_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg  <= scan_idx_next;
        best_key_reg  <= best_key_next;
        prev_key_reg  <= prev_key_next;
        cand_reg      <= cand_next;
        j_reg         <= j_next;
        e_reg         <= e_next;
        iw_reg        <= iw_next;
        ih_reg        <= ih_next;
        aw_reg        <= aw_next;
        ah_reg        <= ah_next;
        bw_reg        <= bw_next;
        bh_reg        <= bh_next;
        inter_reg     <= inter_next;
        area_a_reg    <= area_a_next;
        area_b_reg    <= area_b_next;
        uni_reg       <= uni_next;
        prod_reg      <= prod_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
        out_rec_reg   <= out_rec_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_found      = out_found_reg;
    assign out_rec        = out_rec_reg;
    assign out_overflowed = out_ovf_reg;
    assign out_last       = out_last_reg;

endmodule
`default_nettype wire

@@ hw/rtl/score_sorted_box_suppression.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// score_sorted_box_suppression
// Greedy IoU box suppression over a score sorted candidate set.
// ----------------------------------------------------------------------------
// Candidate words are taken one per clock while the back end is idle, and those
// that pass the score threshold go to the candidate store while it has room; a
// two word queue sits between input and store, so the input keeps taking words
// while the back end is busy for a short while. The work of a finish word is set
// by the single read port of the candidate store: each box taken in score order
// needs one scan of the store, a fetch, one comparison with each already kept
// box and a write to record it when it is kept. Each result is then read from
// the kept list and held on the output until it is accepted, before the next is
// read. No input is taken from the finish word until its last result has been
// accepted, beyond what the queue holds.
module score_sorted_box_suppression #(
    parameter int MAX_CANDIDATES = sbs_pkg::MAX_CANDIDATES_DEF,
    parameter int MAX_KEEP       = sbs_pkg::MAX_KEEP_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [sbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sbs_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           kind,
    input  wire logic [sbs_pkg::EDGE_W-1:0]     left_edge,
    input  wire logic [sbs_pkg::EDGE_W-1:0]     top_edge,
    input  wire logic [sbs_pkg::EDGE_W-1:0]     right_edge,
    input  wire logic [sbs_pkg::EDGE_W-1:0]     bottom_edge,
    input  wire logic [sbs_pkg::SCORE_W-1:0]    confidence,
    input  wire logic [sbs_pkg::TAG_W-1:0]      tag,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                found,
    output logic      [sbs_pkg::EDGE_W-1:0]     out_left,
    output logic      [sbs_pkg::EDGE_W-1:0]     out_top,
    output logic      [sbs_pkg::EDGE_W-1:0]     out_right,
    output logic      [sbs_pkg::EDGE_W-1:0]     out_bottom,
    output logic      [sbs_pkg::SCORE_W-1:0]    out_confidence,
    output logic      [sbs_pkg::TAG_W-1:0]      out_tag,
    output logic                                overflowed,
    output logic                                last
);

    logic [sbs_pkg::SCORE_W-1:0] score_thr_reg;
    logic [sbs_pkg::SCORE_W-1:0] overlap_thr_reg;
    logic [sbs_pkg::LIMIT_W-1:0] keep_limit_reg;
    logic                        cmd_valid, cmd_ready;
    sbs_pkg::cmd_t               cmd;
    sbs_pkg::rec_t               res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_thr_reg   <= sbs_pkg::SCORE_THR_RST;
            overlap_thr_reg <= sbs_pkg::OVERLAP_THR_RST;
            keep_limit_reg  <= sbs_pkg::KEEP_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                sbs_pkg::CFG_SCORE_THR:   score_thr_reg   <= cfg_data;
                sbs_pkg::CFG_OVERLAP_THR: overlap_thr_reg <= cfg_data;
                sbs_pkg::CFG_KEEP_LIMIT:  keep_limit_reg  <= cfg_data[sbs_pkg::LIMIT_W-1:0];
                default:                  ;
            endcase
        end
    end

    sbs_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .left_edge       (left_edge),
        .top_edge        (top_edge),
        .right_edge      (right_edge),
        .bottom_edge     (bottom_edge),
        .confidence      (confidence),
        .tag             (tag),
        .score_thr       (score_thr_reg),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_ready       (cmd_ready)
    );

    sbs_back #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .MAX_KEEP       (MAX_KEEP)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_valid         (cmd_valid),
        .cmd               (cmd),
        .cmd_ready         (cmd_ready),
        .overlap_threshold (overlap_thr_reg),
        .keep_limit        (keep_limit_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_found         (found),
        .out_rec           (res),
        .out_overflowed    (overflowed),
        .out_last          (last)
    );

    assign out_left       = res.left;
    assign out_top        = res.top;
    assign out_right      = res.right;
    assign out_bottom     = res.bottom;
    assign out_confidence = res.score;
    assign out_tag        = res.tag;

endmodule
`default_nettype wire
